@@ rtl/core/smgm_pkg.sv @@
package smgm_pkg;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned RAND_W = 16;
  localparam int unsigned CNT_W = 11;
  localparam int unsigned MAX_SAMPLES = 1024;
  localparam logic [63:0] LN2_Q32 = 64'd2977044472;
  localparam logic signed [31:0] HALF_LN_2PI_Q16 = 32'sd60223;
  localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_MOVE  = 1'b1;

  // One queued request passed from front to back.
  typedef struct packed {
    logic [9:0]         sample_index;
    logic signed [31:0] sample_value;
    logic               mode;
    logic signed [31:0] walker_mean;
    logic signed [31:0] walker_sigma;
    logic signed [31:0] partner_mean;
    logic signed [31:0] partner_sigma;
    logic [15:0]        stretch_random;
    logic [15:0]        accept_random;
  } req_t;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) return SAT_MAX;
    if (v < -36'sd2147483648) return SAT_MIN;
    return v[31:0];
  endfunction
endpackage

@@ rtl/core/smgm_ram.sv @@
module smgm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/core/smgm_front.sv @@
// Two-entry request queue; takes start while the back is busy.
module smgm_front (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  smgm_pkg::req_t req_in,
  output logic         busy,
  output logic         q_valid,
  output smgm_pkg::req_t q_req,
  input  logic         q_pop
);
  import smgm_pkg::*;

  req_t slot [2];
  logic rd_ptr, wr_ptr;
  logic [1:0] count;
  logic push;

  assign busy = (count == 2'd2);
  assign push = start && !busy;
  assign q_valid = (count != 2'd0);
  assign q_req = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= req_in;
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (q_pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

@@ rtl/core/smgm_back.sv @@
// Sequencer: proposal, logs, two likelihood sums via a serial divider.
module smgm_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  smgm_pkg::req_t        q_req,
  output logic                  q_pop,
  input  logic [10:0]           sample_count,
  output logic                  done,
  output logic signed [31:0]    new_mean,
  output logic signed [31:0]    new_sigma,
  output logic                  accepted
);
  import smgm_pkg::*;

  localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int NW = $clog2(MAX_SAMPLES + 1) + 1;

  localparam logic [3:0] S_IDLE = 4'd0, S_Z = 4'd1, S_PM = 4'd2, S_PS = 4'd3,
                         S_DEC = 4'd4, S_LN = 4'd5, S_SQ = 4'd6, S_LIKE = 4'd7,
                         S_DIV = 4'd8, S_ACC = 4'd9, S_CMP = 4'd10, S_OUT = 4'd11,
                         S_LNM = 4'd12, S_RD = 4'd13;

  logic [3:0] state;
  req_t r;
  logic signed [31:0] z, tm, ts;
  logic [1:0] ln_sel;       // 0 z, 1 sigma, 2 u2
  logic pass;               // 0 proposal, 1 walker
  logic signed [35:0] lnz, lnu, ls, acc, like_t;
  logic [31:0] ln_v;
  logic [4:0] ln_k, ln_i;
  logic [31:0] ln_m;
  logic [15:0] ln_f;
  logic signed [54:0] ln_prod;
  logic [63:0] s2, dev2, rem;
  logic [30:0] nbits;       // low dividend bits still to shift in
  logic [31:0] quo_full;
  logic [5:0] div_i;
  logic [NW-1:0] idx, n_eff;
  logic acc_r;
  logic [AW-1:0] raddr;
  logic [31:0] rdata;
  logic signed [32:0] diff;
  logic signed [64:0] prod;

  smgm_ram #(.WIDTH(32), .DEPTH(MAX_SAMPLES)) u_store (
    .clk(clk), .we(state == S_IDLE && q_valid && q_req.mode == MODE_WRITE &&
                   {22'd0, q_req.sample_index} < MAX_SAMPLES),
    .waddr(q_req.sample_index[AW-1:0]), .wdata(q_req.sample_value),
    .raddr(raddr), .rdata(rdata)
  );

  assign raddr = idx[AW-1:0];
  assign q_pop = (state == S_IDLE) && q_valid;

  logic signed [31:0] mu, sg;
  assign mu = pass ? r.walker_mean : tm;
  assign sg = pass ? r.walker_sigma : ts;
  assign n_eff = ({{(NW-11){1'b0}}, sample_count} > MAX_SAMPLES) ?
                 NW'(MAX_SAMPLES) : NW'(sample_count);

  // stretch factor (65536 + u1)^2 >> 17
  logic [16:0] zb;
  logic [33:0] zsq;
  assign zb = {1'b1, r.stretch_random};
  assign zsq = zb * zb;

  logic signed [32:0] dev;
  logic [31:0] mag;
  assign dev = {rdata[31], rdata} - {mu[31], mu};
  assign mag = dev[32] ? 32'(-dev) : 32'(dev);

  logic [63:0] sq, msq, rem_sh;
  assign sq = ln_m * ln_m;
  assign msq = sq >> 30;
  assign rem_sh = {rem[62:0], nbits[30]};

  // log2 in Q6.16 times ln 2 in Q32
  logic signed [21:0] l2;
  logic signed [54:0] ln_mul;
  assign l2 = $signed({6'({1'b0, ln_k}) - 6'd16, ln_f});
  assign ln_mul = l2 * $signed({1'b0, LN2_Q32[31:0]});

  logic signed [35:0] term, sum;
  always_comb begin
    term = sat32(36'(-$signed({4'd0, quo_full})) - ls - 36'(HALF_LN_2PI_Q16));
    sum = sat32(acc + term);
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (q_valid && q_req.mode == MODE_MOVE) begin
          r <= q_req; state <= S_Z;
        end
        S_Z: begin
          z <= {15'd0, zsq[33:17]};
          diff <= {r.walker_mean[31], r.walker_mean} -
                  {r.partner_mean[31], r.partner_mean};
          pass <= 1'b0;
          state <= S_PM;
        end
        S_PM: begin
          prod <= $signed({1'b0, z[16:0]}) * diff;
          state <= S_PS;
        end
        S_PS: begin
          if (!pass) begin
            tm <= sat32(36'(r.partner_mean) + 36'((prod + 65'sd32768) >>> 16));
            diff <= {r.walker_sigma[31], r.walker_sigma} -
                    {r.partner_sigma[31], r.partner_sigma};
            pass <= 1'b1; state <= S_PM;
          end else begin
            ts <= sat32(36'(r.partner_sigma) + 36'((prod + 65'sd32768) >>> 16));
            state <= S_DEC;
          end
        end
        S_DEC: begin
          pass <= 1'b0;
          if (ts <= 0) begin
            acc_r <= 1'b0; state <= S_OUT;
          end else if (r.walker_sigma <= 0 || r.accept_random == 16'd0) begin
            acc_r <= 1'b1; state <= S_OUT;
          end else begin
            ln_sel <= 2'd0; ln_v <= z; state <= S_LN;
          end
        end
        S_LN: begin  // leading-one scan, one bit per cycle
          ln_k <= 5'd31; ln_i <= 5'd0; ln_f <= 16'd0;
          state <= S_LNM;
        end
        S_LNM: begin
          if (!ln_v[ln_k] && ln_k != 5'd0) ln_k <= ln_k - 5'd1;
          else begin
            ln_m <= (ln_k == 5'd31) ? (ln_v >> 1) : (ln_v << (5'd30 - ln_k));
            state <= S_SQ;
          end
        end
        S_SQ: begin
          if (ln_i != 5'd16) begin
            ln_i <= ln_i + 5'd1;
            if (msq[31]) begin
              ln_m <= msq[32:1]; ln_f <= {ln_f[14:0], 1'b1};
            end else begin
              ln_m <= msq[31:0]; ln_f <= {ln_f[14:0], 1'b0};
            end
          end else begin
            ln_prod <= ln_mul;
            state <= S_ACC;
          end
        end
        S_ACC: begin
          priority case (ln_sel)
            2'd0: begin
              lnz <= 36'((ln_prod + 55'sh8000_0000) >>> 32);
              ln_sel <= 2'd1; ln_v <= ts; state <= S_LN;
            end
            2'd1: begin
              ls <= 36'((ln_prod + 55'sh8000_0000) >>> 32);
              s2 <= $unsigned(sg) * $unsigned(sg);
              acc <= '0; idx <= '0; state <= S_RD;
            end
            default: begin
              lnu <= 36'((ln_prod + 55'sh8000_0000) >>> 32);
              state <= S_CMP;
            end
          endcase
        end
        S_RD: begin  // store read issued; data valid in S_DIV
          if (idx == n_eff) state <= S_LIKE;
          else state <= S_DIV;
          div_i <= 6'd0;
        end
        S_DIV: begin  // restoring division, 31 quotient bits
          if (div_i == 6'd0) begin
            dev2 <= mag * mag;
            div_i <= 6'd1;
          end else if (div_i == 6'd1) begin
            // term caps when dev2 >= s2 * 65536
            if ((dev2 >> 16) >= s2) begin
              quo_full <= 32'h8000_0000; div_i <= 6'd33;
            end else begin
              rem <= {16'd0, dev2[63:16]};
              nbits <= {dev2[15:0], 15'd0};
              quo_full <= '0; div_i <= 6'd2;
            end
          end else if (div_i == 6'd33) begin
            acc <= sum; idx <= idx + 1'b1; state <= S_RD;
          end else begin
            if (rem_sh >= s2) begin
              rem <= rem_sh - s2; quo_full <= {quo_full[30:0], 1'b1};
            end else begin
              rem <= rem_sh; quo_full <= {quo_full[30:0], 1'b0};
            end
            nbits <= {nbits[29:0], 1'b0};
            div_i <= div_i + 6'd1;
          end
        end
        S_LIKE: begin
          if (!pass) begin
            like_t <= acc; pass <= 1'b1;
            ln_sel <= 2'd1; ln_v <= r.walker_sigma; state <= S_LN;
          end else begin
            ls <= acc;
            ln_sel <= 2'd2; ln_v <= {16'd0, r.accept_random}; state <= S_LN;
          end
        end
        S_CMP: begin
          acc_r <= (lnz + like_t - ls) > lnu; state <= S_OUT;
        end
        S_OUT: begin
          new_mean <= acc_r ? tm : r.walker_mean;
          new_sigma <= acc_r ? ts : r.walker_sigma;
          accepted <= acc_r;
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/core/stretch_move_gaussian_mcmc.sv @@
// Stretch-move sampler for one Gaussian walker. Mode 0 requests write a
// data sample; mode 1 requests run a full move and produce one result on
// new_mean/new_sigma/accepted, marked by done for one cycle; the receiver
// cannot stall it. A two-entry queue accepts requests while a move runs;
// busy is high when it is full. A write is done as the back end pops it
// while idle. A move can end early (invalid sigma or accept random zero).
// A full move does the proposal work, four natural logs (bit scan plus
// 16 squarings each), and for each of the two likelihood sums one read
// and a 31-step restoring divide per stored sample (the divide is
// skipped when the square term caps).
module stretch_move_gaussian_mcmc (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we,
  input  logic [10:0]        cfg_wdata,
  input  logic               mode,
  input  logic [9:0]         sample_index,
  input  logic signed [31:0] sample_value,
  input  logic signed [31:0] walker_mean,
  input  logic signed [31:0] walker_sigma,
  input  logic signed [31:0] partner_mean,
  input  logic signed [31:0] partner_sigma,
  input  logic [15:0]        stretch_random,
  input  logic [15:0]        accept_random,
  output logic               done,
  output logic signed [31:0] new_mean,
  output logic signed [31:0] new_sigma,
  output logic               accepted
);
  import smgm_pkg::*;

  logic [10:0] sample_count;
  req_t req_in, q_req;
  logic q_valid, q_pop;

  always_ff @(posedge clk) begin
    if (rst) sample_count <= 11'd1;
    else if (cfg_we) sample_count <= cfg_wdata;
  end

  assign req_in = '{sample_index: sample_index, sample_value: sample_value,
                    mode: mode, walker_mean: walker_mean,
                    walker_sigma: walker_sigma, partner_mean: partner_mean,
                    partner_sigma: partner_sigma,
                    stretch_random: stretch_random,
                    accept_random: accept_random};

  smgm_front u_front (
    .clk(clk), .rst(rst), .start(start), .req_in(req_in), .busy(busy),
    .q_valid(q_valid), .q_req(q_req), .q_pop(q_pop)
  );

  smgm_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_req(q_req), .q_pop(q_pop),
    .sample_count(sample_count), .done(done), .new_mean(new_mean),
    .new_sigma(new_sigma), .accepted(accepted)
  );
endmodule
